// ----- src/aos_pkg.sv -----
// Shared constants, codes and handshake structs for the arpeggiator octave stepper.
`default_nettype none

package aos_pkg;

  // Ticks in one bar of the host clock
  localparam int unsigned TICKS_PER_BAR = 384;

  // Item kinds carried in in_tuser
  localparam logic [1:0] OP_NOTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_OCTAVE_SPAN   = 2'd0;
  localparam logic [1:0] REG_STEPS_PER_BAR = 2'd1;
  localparam logic [1:0] REG_DOWN_UP_MODE  = 2'd2;

  // Port widths
  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 40;

  // Serial datapath widths
  localparam int unsigned DVD_W = 32;
  localparam int unsigned DSR_W = 16;
  localparam int unsigned CNT_W = 6;

  // Iteration counts for the two divider passes
  localparam logic [CNT_W-1:0] STEP_ITERS = CNT_W'(DSR_W);
  localparam logic [CNT_W-1:0] MOD_ITERS  = CNT_W'(DVD_W);

  // Bar length, left aligned so a 16-step pass yields the step length
  localparam logic [DVD_W-1:0] BAR_DIVIDEND = {DSR_W'(TICKS_PER_BAR), {(DVD_W-DSR_W){1'b0}}};

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] iters;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DSR_W-1:0] quo;
    logic [DSR_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] tick;
    logic [31:0] wstart;
    logic [31:0] wlen;
  } win_req_t;

  typedef struct packed {
    logic done;
    logic ok;
  } win_rsp_t;

endpackage

`default_nettype wire

// ----- src/aos_serial_div.sv -----
// Restoring divider, one quotient bit per cycle, shared for step length and tick modulo.
`default_nettype none

module aos_serial_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aos_pkg::div_req_t req,
  output aos_pkg::div_rsp_t      rsp
);
  import aos_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DSR_W-1:0] rem_r;
  logic [DSR_W-1:0] quo_r;
  logic [DSR_W+1:0] diff;
  logic             fits;

  // Trial subtract of the divisor from the partial remainder
  assign diff = {1'b0, rem_r, dvd_r[DVD_W-1]} - {2'b00, dsr_r};
  assign fits = ~diff[DSR_W+1];

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= fits ? diff[DSR_W-1:0] : {rem_r[DSR_W-2:0], dvd_r[DVD_W-1]};
      quo_r <= {quo_r[DSR_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ----- src/aos_win_serial.sv -----
// Bit-serial window check: tick >= start and tick - start <= length, LSB first.
`default_nettype none

module aos_win_serial (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire aos_pkg::win_req_t req,
  output aos_pkg::win_rsp_t      rsp
);
  import aos_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      t_r;
  logic [31:0]      s_r;
  logic [31:0]      l_r;
  logic             borrow_r;
  logic             gt_r;
  logic             d_bit;
  logic             borrow_nxt;

  // One bit of tick - start
  assign d_bit      = t_r[0] ^ s_r[0] ^ borrow_r;
  assign borrow_nxt = (~t_r[0] & s_r[0]) | (~(t_r[0] ^ s_r[0]) & borrow_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= MOD_ITERS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift operands; the higher bit that differs decides the compare
  always_ff @(posedge clk) begin
    if (req.start) begin
      t_r      <= req.tick;
      s_r      <= req.wstart;
      l_r      <= req.wlen;
      borrow_r <= 1'b0;
      gt_r     <= 1'b0;
    end else if (busy_r) begin
      t_r      <= {1'b0, t_r[31:1]};
      s_r      <= {1'b0, s_r[31:1]};
      l_r      <= {1'b0, l_r[31:1]};
      borrow_r <= borrow_nxt;
      if (d_bit != l_r[0]) begin
        gt_r <= d_bit;
      end
    end
  end

  // Final borrow means tick lies before the start
  assign rsp.done = done_r;
  assign rsp.ok   = ~borrow_r & ~gt_r;

endmodule

`default_nettype wire

// ----- src/arpeggiator_octave_stepper.sv -----
// Top level: held note, configuration, sequencer and output register of the arpeggiator.
//
// Usage:
//   in_ channel: in_tuser carries the item kind (note, tick, clear); in_tdata the fields.
//   A note or clear item is absorbed while the block stays idle and produces no result.
//   A tick item runs the shared serial divider twice: first for the step
//   length (bar ticks / steps_per_bar), then for tick modulo step while
//   the window check shifts through the same 32 bits. The divider yields
//   one quotient bit per cycle; in_tready is low until the tick item is done.
//   A tick that passes all checks leaves one note-on in the out_ register;
//   a tick with no root or zero rate is absorbed and the block stays idle.
//   out_ channel: the result waits in the output register until out_tready;
//   the next item is accepted while it waits, and only a further note-on
//   waits for the register to empty.
//   cfg_ channel: always ready; write only while the block is idle.
//   Reset (rst_n low, synchronous) loads the register defaults, clears the
//   held note and drops out_tvalid.
`default_nettype none

module arpeggiator_octave_stepper (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: note_pitch[6:0], note_velocity[13:7], window_start[45:14],
  //           window_length[77:46], tick_now[109:78], midi_channel[113:110], zero pad
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [aos_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: op[1:0]
  input  wire logic [1:0]                       in_tuser,
  // out_tdata: out_channel[3:0], out_pitch[11:4], out_velocity[18:12],
  //            gate_ticks[34:19], zero pad
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [aos_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [7:0]                       cfg_data
);
  import aos_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_MOD, S_EMIT} state_t;

  state_t           state_r;
  logic [3:0]       span_r;
  logic [7:0]       spb_r;
  logic             mode_r;
  logic [6:0]       root_r;
  logic [6:0]       vel_r;
  logic [31:0]      start_r;
  logic [31:0]      len_r;
  logic [3:0]       oct_r;
  logic             rising_r;
  logic [31:0]      tick_r;
  logic [3:0]       chan_r;
  logic [DSR_W-1:0] step_r;
  logic             out_valid_r;
  logic [3:0]       out_chan_r;
  logic [7:0]       out_pitch_r;
  logic [6:0]       out_vel_r;
  logic [15:0]      out_gate_r;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  win_req_t         win_req;
  win_rsp_t         win_rsp;

  logic             in_acc;
  logic             tick_go;
  logic             step_ok;
  logic             emit_go;
  logic [7:0]       pitch;
  logic [3:0]       oct_nxt;
  logic             rising_nxt;

  // Input fields
  logic [6:0]  f_pitch;
  logic [6:0]  f_vel;
  logic [31:0] f_wstart;
  logic [31:0] f_wlen;
  logic [31:0] f_tick;
  logic [3:0]  f_chan;

  assign f_pitch  = in_tdata[6:0];
  assign f_vel    = in_tdata[13:7];
  assign f_wstart = in_tdata[45:14];
  assign f_wlen   = in_tdata[77:46];
  assign f_tick   = in_tdata[109:78];
  assign f_chan   = in_tdata[113:110];

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid & in_tready;
  assign tick_go   = in_acc & (in_tuser == OP_TICK) & (root_r != 7'd0) & (spb_r != 8'd0);
  assign step_ok   = (state_r == S_STEP) & div_rsp.done & (div_rsp.quo != '0);
  assign emit_go   = (state_r == S_EMIT) & (~out_valid_r | out_tready);

  // Divider requests: step length from idle, tick modulo after the step pass
  always_comb begin
    div_req.start = tick_go | step_ok;
    if (state_r == S_IDLE) begin
      div_req.iters    = STEP_ITERS;
      div_req.dividend = BAR_DIVIDEND;
      div_req.divisor  = {{(DSR_W-8){1'b0}}, spb_r};
    end else begin
      div_req.iters    = MOD_ITERS;
      div_req.dividend = tick_r;
      div_req.divisor  = div_rsp.quo;
    end
  end

  assign win_req.start  = step_ok;
  assign win_req.tick   = tick_r;
  assign win_req.wstart = start_r;
  assign win_req.wlen   = len_r;

  aos_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  aos_win_serial u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (win_req),
    .rsp   (win_rsp)
  );

  // Pitch from the current octave: root + 8*oct + 4*oct, wrapped to 8 bits
  assign pitch = {1'b0, root_r} + {1'b0, oct_r, 3'b000} + {2'b00, oct_r, 2'b00};

  // Octave ping-pong in down-up mode with a nonzero span, saturating at both ends; else held
  always_comb begin
    oct_nxt    = oct_r;
    rising_nxt = rising_r;
    if (mode_r && (span_r != 4'd0)) begin
      if (rising_r) begin
        if (oct_r != 4'd15) begin
          oct_nxt = oct_r + 4'd1;
        end
      end else if (oct_r != 4'd0) begin
        oct_nxt = oct_r - 4'd1;
      end
      if (oct_nxt == 4'd0) begin
        rising_nxt = 1'b1;
      end else if (oct_nxt >= span_r) begin
        rising_nxt = 1'b0;
      end
    end
  end

  // Sequencer, held note, configuration and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      span_r      <= 4'd0;
      spb_r       <= 8'd4;
      mode_r      <= 1'b0;
      root_r      <= 7'd0;
      vel_r       <= 7'd127;
      start_r     <= 32'd0;
      len_r       <= 32'd0;
      oct_r       <= 4'd0;
      rising_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_OCTAVE_SPAN:   span_r <= cfg_data[3:0];
          REG_STEPS_PER_BAR: spb_r  <= cfg_data;
          REG_DOWN_UP_MODE:  mode_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_tuser)
              OP_NOTE: begin
                root_r   <= f_pitch;
                vel_r    <= f_vel;
                start_r  <= f_wstart;
                len_r    <= f_wlen;
                oct_r    <= span_r;
                rising_r <= 1'b0;
              end
              OP_CLEAR: begin
                root_r  <= 7'd0;
                vel_r   <= 7'd127;
                start_r <= 32'd0;
                len_r   <= 32'd0;
              end
              default: ;
            endcase
            if (tick_go) begin
              state_r <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (div_rsp.done) begin
            state_r <= step_ok ? S_MOD : S_IDLE;
          end
        end
        S_MOD: begin
          // both serial units start together, run MOD_ITERS passes and finish together
          if (div_rsp.done && win_rsp.done) begin
            state_r <= (win_rsp.ok && (div_rsp.rem == '0)) ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            oct_r    <= oct_nxt;
            rising_r <= rising_nxt;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Tick payload, step length and result payload
  always_ff @(posedge clk) begin
    if (tick_go) begin
      tick_r <= f_tick;
      chan_r <= f_chan;
    end
    if (step_ok) begin
      step_r <= div_rsp.quo;
    end
    if (emit_go) begin
      out_chan_r  <= chan_r;
      out_pitch_r <= pitch;
      out_vel_r   <= vel_r;
      out_gate_r  <= (step_r - 16'd1) >> 1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_gate_r, out_vel_r, out_pitch_r, out_chan_r};

endmodule

`default_nettype wire

// ----- src/aos_checker.sv -----
// Port-level checks for the arpeggiator octave stepper, bound to the top level.
`default_nettype none

module aos_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [1:0]                     in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [aos_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import aos_pkg::*;

  // A stalled item holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out item changed while stalled");

  // A new result only follows a busy cycle of the sequencer
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a tick being worked on");

  // Note and clear items never produce a result on their own
  a_no_result_note: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_NOTE || in_tuser == OP_CLEAR)
      |=> !$rose(out_tvalid))
    else $error("result after a note or clear item");

  // Gate length is bounded by half the bar and the pad bits stay zero
  a_gate_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:19] <= 16'(TICKS_PER_BAR / 2)) && (out_tdata[39:35] == 5'd0))
    else $error("gate length or padding out of range");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

endmodule

bind arpeggiator_octave_stepper aos_checker u_aos_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- bench/arpeggiator_octave_stepper_tb.sv -----
// Self-checking testbench for the arpeggiator octave stepper: stream stimulus and note-on checker.
`timescale 1ns / 1ps

module arpeggiator_octave_stepper_tb;
  import aos_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int ITEM_TARGET    = 1400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int PRINT_LIMIT    = 200;

  // Item kind the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [31:0] win_start;
    logic [31:0] win_len;
    logic [31:0] tick;
    logic [3:0]  chan;
  } arp_item_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [7:0]  pitch;
    logic [6:0]  velocity;
    logic [15:0] gate;
  } note_on_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [1:0]             in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [7:0]             cfg_data  = '0;

  // Predictor copy of registers and held-note state (reset values)
  logic [3:0]  span_q    = 4'd0;
  logic [7:0]  steps_q   = 8'd4;
  logic        down_up_q = 1'b0;
  logic [6:0]  root_q    = 7'd0;
  logic [6:0]  vel_q     = 7'd127;
  logic [31:0] start_q   = 32'd0;
  logic [31:0] len_q     = 32'd0;
  logic [3:0]  octave_q  = 4'd0;
  logic        rising_q  = 1'b0;

  arp_item_t queued_items[$];
  note_on_t  expected_note_ons[$];
  arp_item_t bus_item;
  logic      in_taken = 1'b0;
  int        queued_count = 0;
  int        mismatches = 0;
  int        cycle_count = 0;

  // Sender burst/gap state
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall state
  logic holdoff_arm  = 1'b0;
  logic holdoff_done = 1'b0;
  int   holdoff_count = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  arpeggiator_octave_stepper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Apply one item to the predicted state; returns 1 when a note-on is due
  function automatic bit predict_note_on(input arp_item_t it, output note_on_t res);
    logic [31:0] step;
    res = '0;
    case (it.op)
      OP_NOTE: begin
        root_q   = it.pitch;
        vel_q    = it.velocity;
        start_q  = it.win_start;
        len_q    = it.win_len;
        octave_q = span_q;
        rising_q = 1'b0;
        return 1'b0;
      end
      OP_CLEAR: begin
        root_q  = 7'd0;
        vel_q   = 7'd127;
        start_q = 32'd0;
        len_q   = 32'd0;
        return 1'b0;
      end
      OP_TICK: ;
      default: return 1'b0;
    endcase
    if (root_q == 7'd0) return 1'b0;
    // window test is on the 32-bit offset, only once the tick is at or past the start
    if (it.tick < start_q || (it.tick - start_q) > len_q) return 1'b0;
    if (steps_q == 8'd0) return 1'b0;
    step = TICKS_PER_BAR / steps_q;
    if (step == 32'd0 || (it.tick % step) != 32'd0) return 1'b0;
    res.chan     = it.chan;
    res.pitch    = 8'(root_q + octave_q * 12);
    res.velocity = vel_q;
    res.gate     = 16'((step - 32'd1) / 32'd2);
    // ping-pong octave, saturating at both ends
    if (down_up_q && span_q != 4'd0) begin
      if (rising_q) begin
        if (octave_q < 4'd15) octave_q = octave_q + 4'd1;
      end else if (octave_q > 4'd0) begin
        octave_q = octave_q - 4'd1;
      end
      if (octave_q == 4'd0) rising_q = 1'b1;
      else if (octave_q >= span_q) rising_q = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic arp_item_t rand_item();
    arp_item_t it;
    it.op        = 2'($urandom_range(0, 3));
    it.pitch     = 7'($urandom);
    it.velocity  = 7'($urandom);
    it.win_start = $urandom;
    it.win_len   = $urandom;
    it.tick      = $urandom;
    it.chan      = 4'($urandom);
    return it;
  endfunction

  task automatic queue_item(input arp_item_t it);
    queued_items.push_back(it);
    queued_count++;
  endtask

  task automatic queue_fields(input logic [1:0] op, input logic [6:0] pitch,
                              input logic [6:0] velocity, input logic [31:0] win_start,
                              input logic [31:0] win_len, input logic [31:0] tick,
                              input logic [3:0] chan);
    arp_item_t it;
    it = '{op, pitch, velocity, win_start, win_len, tick, chan};
    queue_item(it);
  endtask

  // A source note followed by a run of ticks on its step grid, with some noise
  task automatic queue_phrase();
    arp_item_t   it;
    logic [31:0] step, base, first, top;
    int unsigned ticks, off, j;
    step  = (steps_q == 8'd0) ? TICKS_PER_BAR : TICKS_PER_BAR / steps_q;
    ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    top   = 32'hFFFF_FFFF / step;
    case ($urandom_range(0, 3))
      0: base = step * $urandom_range(0, 20);
      1: base = step * (top - $urandom_range(0, 12));
      default: base = step * $urandom_range(0, top);
    endcase
    off   = (base < 500) ? $urandom_range(0, base) : $urandom_range(0, 500);
    first = base - off;
    it = rand_item();
    it.op        = OP_NOTE;
    it.pitch     = ($urandom_range(0, 15) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    it.win_start = first;
    it.win_len   = ($urandom_range(0, 4) == 0) ? $urandom :
                   off + step * (ticks - 1) + $urandom_range(0, step);
    queue_item(it);
    for (j = 0; j <= ticks; j++) begin
      it = rand_item();
      case ($urandom_range(0, 11))
        0: ;  // random item of any kind
        1: begin
          it.op   = OP_TICK;
          it.tick = base + step * j + $urandom_range(1, (step > 1) ? step - 1 : 1);
        end
        2: begin
          it.op   = OP_TICK;
          it.tick = first - 32'd1;
        end
        default: begin
          it.op   = OP_TICK;
          it.tick = base + step * j;
        end
      endcase
      queue_item(it);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input logic [3:0] span, input logic [7:0] steps, input logic mode);
    write_reg(REG_OCTAVE_SPAN, {4'd0, span});
    write_reg(REG_STEPS_PER_BAR, steps);
    write_reg(REG_DOWN_UP_MODE, {7'd0, mode});
  endtask

  // Wait until all items are in and every note-on has come out, then let the block settle
  task automatic wait_idle();
    while (queued_items.size() != 0 || in_tvalid || expected_note_ons.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Accepted items and register writes feed the predictor
  always @(posedge clk) begin : accept_items
    note_on_t res;
    in_taken = 1'b0;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OCTAVE_SPAN:   span_q    = cfg_data[3:0];
        REG_STEPS_PER_BAR: steps_q   = cfg_data;
        REG_DOWN_UP_MODE:  down_up_q = cfg_data[0];
        default: ;
      endcase
    end
    if (rst_n && in_tvalid && in_tready) begin
      in_taken = 1'b1;
      if (predict_note_on(bus_item, res)) expected_note_ons.push_back(res);
    end
  end

  // Sender: bursts of items with random gaps
  always @(negedge clk) begin : drive_items
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // item still waiting for in_tready
    end else if (gap_left != 0) begin
      in_tvalid <= 1'b0;
      gap_left--;
    end else if (queued_items.size() != 0) begin
      bus_item = queued_items.pop_front();
      in_tdata  <= {6'd0, bus_item.chan, bus_item.tick, bus_item.win_len,
                    bus_item.win_start, bus_item.velocity, bus_item.pitch};
      in_tuser  <= bus_item.op;
      in_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 7))
          0, 1: gap_left = 0;
          7:    gap_left = $urandom_range(30, 90);
          default: gap_left = $urandom_range(1, 8);
        endcase
      end else begin
        burst_left--;
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Receiver: one long hold-off when armed, otherwise stretches of stall patterns
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holdoff_arm && !holdoff_done) begin
      out_tready <= 1'b0;
      holdoff_count++;
      if (holdoff_count >= HOLDOFF_CYCLES) holdoff_done = 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(1, 60);
      end
      stall_left--;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each note-on with the oldest expectation
  always @(posedge clk) begin : check_note_ons
    note_on_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_note_ons.size() == 0) begin
        report_mismatch($sformatf("note-on with none expected, tdata %h", out_tdata));
      end else begin
        want = expected_note_ons.pop_front();
        if (out_tdata[3:0] !== want.chan)
          report_mismatch($sformatf("channel got %0d want %0d", out_tdata[3:0], want.chan));
        if (out_tdata[11:4] !== want.pitch)
          report_mismatch($sformatf("pitch got %0d want %0d", out_tdata[11:4], want.pitch));
        if (out_tdata[18:12] !== want.velocity)
          report_mismatch($sformatf("velocity got %0d want %0d", out_tdata[18:12],
                                    want.velocity));
        if (out_tdata[34:19] !== want.gate)
          report_mismatch($sformatf("gate got %0d want %0d", out_tdata[34:19], want.gate));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0] span;
    logic [7:0] steps;
    logic       mode;
    int         phase_no;
    int         phase_end;
    int         i;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: step 96, fixed octave
    queue_fields(OP_TICK, 7'd5, 7'd9, 32'd0, 32'd0, 32'd0, 4'd3);           // no root yet
    queue_fields(OP_NOTE, 7'd127, 7'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    queue_fields(OP_TICK, 7'd0, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 4'd15);
    queue_fields(OP_TICK, 7'd127, 7'd0, 32'd0, 32'd0, 32'd96, 4'd0);
    queue_fields(OP_TICK, 7'd1, 7'd1, 32'd0, 32'd0, 32'd95, 4'd7);          // off the grid
    queue_fields(OP_UNUSED, 7'd127, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 4'd15);
    queue_fields(OP_NOTE, 7'd0, 7'd127, 32'd0, 32'hFFFF_FFFF, 32'd0, 4'd0);  // pitch 0: none held
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd192, 4'd1);
    queue_fields(OP_NOTE, 7'd1, 7'd127, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd0, 4'd0);
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd0, 4'd2);           // before the start
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'hFFFF_FF00, 4'd2);
    queue_fields(OP_NOTE, 7'd60, 7'd100, 32'd960, 32'd0, 32'd0, 4'd0);      // one-tick window
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd960, 4'd9);
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd1056, 4'd9);        // past the window
    queue_fields(OP_CLEAR, 7'd77, 7'd33, 32'd5, 32'd5, 32'd5, 4'd5);
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd960, 4'd9);         // cleared
    wait_idle();

    // Falling at zero: note taken with no span, span raised before the ticks
    set_regs(4'd0, 8'd255, 1'b0);
    queue_fields(OP_NOTE, 7'd50, 7'd64, 32'd0, 32'd1000, 32'd0, 4'd0);
    wait_idle();
    set_regs(4'd3, 8'd255, 1'b1);
    for (i = 0; i < 5; i++) queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, i, 4'd4);
    wait_idle();

    // Widest span with the slowest rate: pitch wraps past 255
    set_regs(4'd15, 8'd1, 1'b1);
    queue_fields(OP_NOTE, 7'd127, 7'd5, 32'd0, 32'hFFFF_FFFF, 32'd0, 4'd0);
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd0, 4'd8);
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd383, 4'd8);
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd384, 4'd8);
    wait_idle();

    // Zero rate disables output
    set_regs(4'd10, 8'd0, 1'b1);
    queue_fields(OP_NOTE, 7'd60, 7'd90, 32'd0, 32'hFFFF_FFFF, 32'd0, 4'd0);
    queue_fields(OP_TICK, 7'd0, 7'd0, 32'd0, 32'd0, 32'd0, 4'd6);
    wait_idle();

    // Random phases, each under its own register setting
    phase_no = 0;
    while (queued_count < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0: span = 4'd0;
        1: span = 4'd10;
        2: span = 4'd15;
        default: span = 4'($urandom_range(0, 10));
      endcase
      case ($urandom_range(0, 7))
        0: steps = 8'd0;
        1: steps = 8'd1;
        2: steps = 8'd255;
        3: steps = 8'($urandom_range(193, 255));
        default: steps = 8'($urandom_range(1, 255));
      endcase
      mode = ($urandom_range(0, 3) != 0);
      if (phase_no == 2 && steps == 8'd0) steps = 8'd255;
      set_regs(span, steps, mode);
      // long receiver hold-off while the sender keeps going
      if (phase_no == 2) holdoff_arm = 1'b1;
      phase_end = queued_count + $urandom_range(80, 160);
      while (queued_count < phase_end) queue_phrase();
      wait_idle();
      phase_no++;
    end

    if (expected_note_ons.size() != 0)
      report_mismatch($sformatf("%0d note-ons never produced", expected_note_ons.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- arpeggiator_octave_stepper.f -----
src/aos_pkg.sv
src/aos_serial_div.sv
src/aos_win_serial.sv
src/arpeggiator_octave_stepper.sv
src/aos_checker.sv
bench/arpeggiator_octave_stepper_tb.sv
